@@ design/tcw_pkg.sv @@
// tcw_pkg: shared types and constants for the text console writer
// no dependencies; used by text_console_writer
package tcw_pkg;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_EXEC,
        S_RDATA,
        S_SCROLL,
        S_SCEND,
        S_DONE
    } t_state;

    // command codes carried on tuser
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_PUT  = 2'd0;
    localparam t_cmd CMD_READ = 2'd1;
    localparam t_cmd CMD_SET  = 2'd2;

    // character codes
    typedef logic [7:0] t_char;
    localparam t_char CH_BS    = 8'h08;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_NL    = 8'h0A;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_BLANK = 8'h20;

    // field widths
    localparam int TAB_W     = 6;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CURSOR_W  = 11;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // tab width after reset
    localparam logic [TAB_W-1:0] TAB_RESET = 6'd8;

endpackage

@@ design/tcw_rem_unit.sv @@
// tcw_rem_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on: nothing beyond its parameters
module tcw_rem_unit #(
    parameter int DIVIDEND_W = 11,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVISOR_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_shift;

    logic [DIVISOR_W:0] trial;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    // shift in the next dividend bit and try one subtraction
    always_comb begin
        trial = {r_rem, r_shift[DIVIDEND_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // iteration control and partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_shift <= i_dividend;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_shift <= r_shift << 1;
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/text_console_writer.sv @@
// text_console_writer: teletype console over a COLUMNS x ROWS character store
// depends on: tcw_pkg, tcw_rem_unit
//
//  channel   | direction | fields (lowest bit first)
//  s_axis    | in        | tuser: cmd[1:0]; tdata: char_code[7:0] col[14:8] row[19:15]
//  m_axis    | out       | tdata: cursor_pos[10:0] cell_char[18:11] scrolled[19] rejected[20]
//  cfg       | in        | i_cfg_wr_en, i_cfg_wr_data: tab_width[5:0]
//
// printable, backspace, newline, carriage return and set pass through accept, execute and
// hand over; read adds a state for the registered memory read. a tab first waits for
// the serial remainder unit. a scroll adds a copy sweep, one memory copy per cycle
// through the single read and write port. after reset a clearing pass over all cells
// fills the store with spaces before the first transaction is taken. a stalled output
// holds one result while the next transaction is accepted and executed.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [tcw_pkg::TAB_W-1:0]     i_cfg_wr_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tcw_pkg::S_DATA_W-1:0]  s_axis_tdata,  // char_code, col, row
    input  logic [1:0]                    s_axis_tuser,  // cmd
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]  m_axis_tdata   // cursor_pos, cell_char,
                                                          // scrolled, rejected
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int PW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + COLUMNS + 64);
    localparam int AW    = $clog2(CELLS + COLUMNS);
    localparam int CDW   = $clog2(COLUMNS + 1);
    localparam int DW    = (CDW > tcw_pkg::TAB_W) ? CDW : tcw_pkg::TAB_W;

    // reciprocal of COLUMNS for the cursor column
    localparam int RS    = PW + $clog2(COLUMNS);
    localparam int RK    = ((1 << RS) + COLUMNS - 1) / COLUMNS;
    localparam int KW    = $clog2(RK + 1);
    localparam int PRW   = PW + KW;
    localparam int QW    = PRW - RS;

    localparam logic [NW-1:0] CELLS_N    = NW'(CELLS);
    localparam logic [NW-1:0] COLS_N     = NW'(COLUMNS);
    localparam logic [PW-1:0] COLS_P     = PW'(COLUMNS);
    localparam logic [PW-1:0] BOTTOM_ROW = PW'(COLUMNS * (ROWS - 1));
    localparam logic [AW-1:0] CLR_LAST   = AW'(CELLS - 1);
    localparam logic [AW-1:0] SC_LAST    = AW'(CELLS + COLUMNS - 1);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] CELLS_A    = AW'(CELLS);
    localparam logic [KW-1:0] RECIP      = KW'(RK);

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    // latched transaction
    tcw_pkg::t_cmd               r_cmd;
    tcw_pkg::t_char              r_ch;
    logic [tcw_pkg::COL_W-1:0]   r_col;
    logic [tcw_pkg::ROW_W-1:0]   r_row;

    // console state and result under construction
    logic [PW-1:0]               r_cursor;
    logic [tcw_pkg::TAB_W-1:0]   r_tab;
    tcw_pkg::t_char              r_char;
    logic                        r_scr;
    logic                        r_rej;

    // column of the cursor, refreshed every cycle
    logic [DW-1:0]               r_cur_col;
    logic [DW-1:0]               n_cur_col;
    logic [PRW-1:0]              col_prod;
    logic [QW-1:0]               col_quot;

    // sweep address for clearing and scrolling, delayed scroll write
    logic [AW-1:0]               r_addr;
    logic                        r_sc_v;
    logic                        r_sc_blank;
    logic [PW-1:0]               r_sc_waddr;

    // character store
    tcw_pkg::t_char              r_screen [CELLS];
    tcw_pkg::t_char              r_rd;

    // output register
    logic                        r_m_valid;
    logic [tcw_pkg::M_DATA_W-1:0] r_m_data;

    // decoded input
    tcw_pkg::t_cmd               in_cmd;
    tcw_pkg::t_char              in_ch;
    logic                        in_acc;
    logic                        in_needs_rem;

    // datapath signals
    logic [tcw_pkg::TAB_W-1:0]   tw_eff;
    logic [DW-1:0]               rem_divisor;
    logic                        rem_start;
    logic                        rem_done;
    logic [DW-1:0]               rem;
    logic [NW-1:0]               new_p;
    logic                        need_scroll;
    logic                        coords_ok;
    logic [PW-1:0]               cell_addr;
    logic                        addr_in_screen;
    logic                        out_free;

    // memory port controls
    logic                        w_en;
    logic [PW-1:0]               w_addr;
    tcw_pkg::t_char              w_data;
    logic                        rd_en;
    logic [PW-1:0]               rd_addr;

    // input unpacking and handshake
    assign in_cmd = s_axis_tuser;
    assign in_ch  = s_axis_tdata[7:0];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_needs_rem = (in_cmd == tcw_pkg::CMD_PUT) && (in_ch == tcw_pkg::CH_TAB);
    assign out_free = !r_m_valid || m_axis_tready;

    // tab width zero acts as one
    assign tw_eff      = (r_tab == '0) ? tcw_pkg::TAB_W'(1) : r_tab;
    assign rem_divisor = DW'(tw_eff);
    assign rem_start   = in_acc && in_needs_rem;

    tcw_rem_unit #(
        .DIVIDEND_W (PW),
        .DIVISOR_W  (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_cursor),
        .i_divisor  (rem_divisor),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    // cursor column by reciprocal multiply, the quotient is the row
    always_comb begin
        col_prod  = PRW'(r_cursor) * PRW'(RECIP);
        col_quot  = col_prod[PRW-1:RS];
        n_cur_col = DW'(r_cursor - PW'(col_quot) * COLS_P);
    end

    // new cursor for a put character command
    always_comb begin
        case (r_ch)
            tcw_pkg::CH_NL:  new_p = NW'(r_cursor) + COLS_N - NW'(r_cur_col);
            tcw_pkg::CH_TAB: new_p = NW'(r_cursor) + NW'(tw_eff) - NW'(rem);
            tcw_pkg::CH_CR:  new_p = NW'(r_cursor) - NW'(r_cur_col);
            tcw_pkg::CH_BS:  new_p = (r_cursor == '0) ? '0 : NW'(r_cursor) - NW'(1);
            default:         new_p = NW'(r_cursor) + NW'(1);
        endcase
        need_scroll = (new_p >= CELLS_N);
    end

    // coordinate check and linear cell address
    assign coords_ok = (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS);
    assign cell_addr = PW'(PW'(r_row) * COLS_P + PW'(r_col));
    assign addr_in_screen = (r_addr < CELLS_A);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                if (r_addr == CLR_LAST) n_state = tcw_pkg::S_IDLE;
            end
            tcw_pkg::S_IDLE: begin
                if (in_acc) n_state = in_needs_rem ? tcw_pkg::S_DIV : tcw_pkg::S_EXEC;
            end
            tcw_pkg::S_DIV: begin
                if (rem_done) n_state = tcw_pkg::S_EXEC;
            end
            tcw_pkg::S_EXEC: begin
                if ((r_cmd == tcw_pkg::CMD_PUT) && need_scroll) begin
                    n_state = tcw_pkg::S_SCROLL;
                end else if ((r_cmd == tcw_pkg::CMD_READ) && coords_ok) begin
                    n_state = tcw_pkg::S_RDATA;
                end else begin
                    n_state = tcw_pkg::S_DONE;
                end
            end
            tcw_pkg::S_RDATA:  n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_SCROLL: begin
                if (r_addr == SC_LAST) n_state = tcw_pkg::S_SCEND;
            end
            tcw_pkg::S_SCEND:  n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_DONE: begin
                if (out_free) n_state = tcw_pkg::S_IDLE;
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // state outputs: handshake and memory port controls
    always_comb begin
        s_axis_tready = (r_state == tcw_pkg::S_IDLE);
        w_en    = 1'b0;
        w_addr  = r_cursor;
        w_data  = tcw_pkg::CH_BLANK;
        rd_en   = 1'b0;
        rd_addr = cell_addr;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_addr[PW-1:0];
            end
            tcw_pkg::S_EXEC: begin
                if (r_cmd == tcw_pkg::CMD_PUT) begin
                    if (r_ch == tcw_pkg::CH_BS) begin
                        w_en   = 1'b1;
                        w_addr = new_p[PW-1:0];
                    end else if ((r_ch != tcw_pkg::CH_TAB) && (r_ch != tcw_pkg::CH_NL) &&
                                 (r_ch != tcw_pkg::CH_CR)) begin
                        w_en   = 1'b1;
                        w_data = r_ch;
                    end
                end else if (r_cmd == tcw_pkg::CMD_READ) begin
                    rd_en = coords_ok;
                end
            end
            tcw_pkg::S_SCROLL: begin
                rd_en   = addr_in_screen;
                rd_addr = r_addr[PW-1:0];
                w_en    = r_sc_v;
                w_addr  = r_sc_waddr;
                w_data  = r_sc_blank ? tcw_pkg::CH_BLANK : r_rd;
            end
            tcw_pkg::S_SCEND: begin
                w_en   = r_sc_v;
                w_addr = r_sc_waddr;
                w_data = r_sc_blank ? tcw_pkg::CH_BLANK : r_rd;
            end
            default: ;
        endcase
    end

    // character store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_en) r_screen[w_addr] <= w_data;
        if (rd_en) r_rd <= r_screen[rd_addr];
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // console state, sweep address and result fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_cur_col <= '0;
            r_tab     <= tcw_pkg::TAB_RESET;
            r_addr    <= '0;
            r_sc_v    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_tab <= i_cfg_wr_data;

            // cursor only moves in execute, so the column is settled by the next one
            r_cur_col <= n_cur_col;

            // scroll copy: cell at r_addr lands one row up in the next cycle
            r_sc_v     <= (r_state == tcw_pkg::S_SCROLL);
            r_sc_blank <= !addr_in_screen;
            r_sc_waddr <= PW'(r_addr - COLS_A);

            case (r_state)
                tcw_pkg::S_CLEAR: r_addr <= r_addr + 1'b1;
                tcw_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_cmd  <= in_cmd;
                        r_ch   <= in_ch;
                        r_col  <= s_axis_tdata[14:8];
                        r_row  <= s_axis_tdata[19:15];
                        r_char <= '0;
                        r_scr  <= 1'b0;
                        r_rej  <= 1'b0;
                    end
                end
                tcw_pkg::S_EXEC: begin
                    case (r_cmd)
                        tcw_pkg::CMD_PUT: begin
                            if (need_scroll) begin
                                r_cursor <= BOTTOM_ROW;
                                r_scr    <= 1'b1;
                                r_addr   <= COLS_A;
                            end else begin
                                r_cursor <= new_p[PW-1:0];
                            end
                        end
                        tcw_pkg::CMD_READ: begin
                            if (!coords_ok) r_rej <= 1'b1;
                        end
                        tcw_pkg::CMD_SET: begin
                            if (coords_ok) r_cursor <= cell_addr;
                            else r_rej <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                tcw_pkg::S_RDATA:  r_char <= r_rd;
                tcw_pkg::S_SCROLL: r_addr <= r_addr + 1'b1;
                default: ;
            endcase

            // output register, loaded when the previous result is gone
            if ((r_state == tcw_pkg::S_DONE) && out_free) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {3'b000, r_rej, r_scr, r_char,
                              tcw_pkg::CURSOR_W'(r_cursor)};
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
